FILE: src/nnp_pkg.sv
// Package for the numbered-notation note parser and pitch ratio block.
// Holds character codes, parameter defaults and the constant pitch tables.
// No dependencies; compiled first.
package nnp_pkg;

    // Default values of the top-level parameters.
    localparam int COUNT_WIDTH_DEF    = 7;
    localparam int MANT_FRAC_BITS_DEF = 15;

    // Character codes of the note text.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SHARP = 8'h23;
    localparam logic [7:0] CH_FLAT  = 8'h62;

    // Semitone offset of a scale degree; degree zero (no digit) maps to zero.
    function automatic logic [3:0] deg_step(input logic [2:0] deg);
        logic [3:0] s;
        case (deg)
            3'd1:    s = 4'd0;
            3'd2:    s = 4'd2;
            3'd3:    s = 4'd4;
            3'd4:    s = 4'd5;
            3'd5:    s = 4'd7;
            3'd6:    s = 4'd9;
            3'd7:    s = 4'd11;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    // Canonical scale degree of a pitch class.
    function automatic logic [2:0] pc_degree(input logic [3:0] pc);
        logic [2:0] d;
        case (pc)
            4'd0, 4'd1:   d = 3'd1;
            4'd2, 4'd3:   d = 3'd2;
            4'd4:         d = 3'd3;
            4'd5, 4'd6:   d = 3'd4;
            4'd7, 4'd8:   d = 3'd5;
            4'd9, 4'd10:  d = 3'd6;
            4'd11:        d = 3'd7;
            default:      d = 3'd0;
        endcase
        return d;
    endfunction

    // Sharp flag of a pitch class.
    function automatic logic pc_sharp(input logic [3:0] pc);
        logic s;
        case (pc)
            4'd1, 4'd3, 4'd6, 4'd8, 4'd10: s = 1'b1;
            default:                       s = 1'b0;
        endcase
        return s;
    endfunction

    // 2^(pc/12) in Q1.30, rounded to nearest.
    function automatic logic [31:0] ratio_q30(input logic [3:0] pc);
        logic [31:0] r;
        case (pc)
            4'd0:    r = 32'd1073741824;
            4'd1:    r = 32'd1137589835;
            4'd2:    r = 32'd1205234447;
            4'd3:    r = 32'd1276901417;
            4'd4:    r = 32'd1352829926;
            4'd5:    r = 32'd1433273380;
            4'd6:    r = 32'd1518500250;
            4'd7:    r = 32'd1608794974;
            4'd8:    r = 32'd1704458901;
            4'd9:    r = 32'd1805811301;
            4'd10:   r = 32'd1913190429;
            4'd11:   r = 32'd2026954652;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // Ratio mantissa rounded half up to frac_bits fraction bits, kept to 16 bits.
    function automatic logic [15:0] ratio_mantissa(input logic [3:0] pc, input int frac_bits);
        logic [31:0] t;
        int          sh;
        t  = ratio_q30(pc);
        sh = 30 - frac_bits;
        if (sh > 0) begin
            t = (t + (32'd1 << (sh - 1))) >> sh;
        end
        return t[15:0];
    endfunction

endpackage

FILE: src/nnp_in_if.sv
// Input channel of the note parser: one text character per transfer.
// Stands alone; compiled after nnp_pkg.
interface nnp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       end_of_text;

    modport source (output valid, output text_char, output end_of_text, input ready);
    modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

FILE: src/nnp_out_if.sv
// Result channel of the note parser: one canonical note and ratio per transfer.
// Stands alone; compiled after nnp_pkg.
interface nnp_out_if;
    logic              valid;
    logic              ready;
    logic [2:0]        base_digit;
    logic              sharp_flag;
    logic signed [7:0] octave;
    logic [3:0]        pitch_class;
    logic [15:0]       ratio_mantissa;

    modport source (output valid, output base_digit, output sharp_flag, output octave,
                    output pitch_class, output ratio_mantissa, input ready);
    modport sink   (input valid, input base_digit, input sharp_flag, input octave,
                    input pitch_class, input ratio_mantissa, output ready);
endinterface

FILE: src/numbered_note_parse_and_pitch_ratio.sv
// Numbered-notation note parser with equal-temperament pitch ratio output.
// Uses nnp_pkg and the channel interfaces nnp_in_if and nnp_out_if.
//
// The block takes one character of a note per transfer and can accept a new
// character every clock cycle unless a final character waits for the parse stage
// to hand on a finished note. A note passes three registers: the input register,
// the parse stage (where the saturating octave and accidental counters and the
// degree register are updated, one character per cycle while not stalled), and
// the output register, in front of which the semitone sum is floor-divided by 12
// with one reciprocal multiply and a single correction. A result can wait in the
// output register while later characters keep flowing into the earlier stages.
// A '0' or a note without a digit gives a result with all fields zero. After the
// final character the parse state returns to zero for the next note.
module numbered_note_parse_and_pitch_ratio #(
    parameter int COUNT_WIDTH        = nnp_pkg::COUNT_WIDTH_DEF,
    parameter int MANTISSA_FRAC_BITS = nnp_pkg::MANT_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nnp_in_if.sink     i_in,
    nnp_out_if.source  o_out
);
    import nnp_pkg::*;

    // Sum is the degree offset plus the accidental count plus a multiple of 12
    // that keeps it positive.
    localparam int SUM_W  = COUNT_WIDTH + 3;
    localparam int DIV_K  = SUM_W + 4;
    localparam int PROD_W = 2 * SUM_W + 1;
    localparam int OCT_W  = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
    localparam logic [SUM_W:0]       DIV_M   = (SUM_W + 1)'((64'd1 << DIV_K) / 64'd12);
    localparam logic [SUM_W-1:0]     SUM_OFF = SUM_W'(64'd12 << (COUNT_WIDTH - 1));
    localparam logic [OCT_W-1:0]     Q_BIAS  = OCT_W'(64'd1 << (COUNT_WIDTH - 1));
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_last;

    // Parse state.
    logic [2:0]                    r_deg, n_deg;
    logic signed [COUNT_WIDTH-1:0] r_acc, n_acc;
    logic signed [COUNT_WIDTH-1:0] r_oct, n_oct;
    logic                          r_rest_seen, n_rest_seen;

    // Parse stage result of a finished note.
    logic                          r_s_valid;
    logic                          r_s_rest;
    logic [SUM_W-1:0]              r_s_sum;
    logic signed [COUNT_WIDTH-1:0] r_s_oct;

    // Output register.
    logic              r_o_valid;
    logic [2:0]        r_o_base;
    logic              r_o_sharp;
    logic signed [7:0] r_o_oct;
    logic [3:0]        r_o_pc;
    logic [15:0]       r_o_mant;

    logic o_adv, s2_move, s2_free, s1_move;
    logic [SUM_W-1:0] p_sum;

    logic [PROD_W-1:0]      prod;
    logic [COUNT_WIDTH-1:0] q0, q;
    logic [SUM_W-1:0]       r0;
    logic                   over;
    logic [3:0]             pc;
    logic [OCT_W-1:0]       oct_full;

    // Stage flow: each stage moves when the one after it can take its item.
    assign o_adv      = !r_o_valid || o_out.ready;
    assign s2_move    = r_s_valid && o_adv;
    assign s2_free    = !r_s_valid || o_adv;
    assign s1_move    = r_in_valid && (!r_last || s2_free);
    assign i_in.ready = !r_in_valid || s1_move;

    // Input register: capture each transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (s1_move) begin
            r_in_valid <= 1'b0;
        end
        if (i_in.valid && i_in.ready) begin
            r_char <= i_in.text_char;
            r_last <= i_in.end_of_text;
        end
    end

    // Apply one character to the parse state with saturating counters.
    always_comb begin
        n_deg       = r_deg;
        n_acc       = r_acc;
        n_oct       = r_oct;
        n_rest_seen = r_rest_seen;
        if (!r_rest_seen) begin
            if (r_char == CH_ZERO) begin
                n_deg       = 3'd0;
                n_acc       = '0;
                n_oct       = '0;
                n_rest_seen = 1'b1;
            end else if (r_char inside {[CH_ONE:CH_SEVEN]}) begin
                n_deg = r_char[2:0];
            end else if (r_char == CH_PLUS) begin
                if (r_oct != CNT_MAX) n_oct = r_oct + 1'b1;
            end else if (r_char == CH_MINUS) begin
                if (r_oct != CNT_MIN) n_oct = r_oct - 1'b1;
            end else if (r_char == CH_SHARP) begin
                if (r_acc != CNT_MAX) n_acc = r_acc + 1'b1;
            end else if (r_char == CH_FLAT) begin
                if (r_acc != CNT_MIN) n_acc = r_acc - 1'b1;
            end
        end
        p_sum = SUM_OFF + SUM_W'(deg_step(n_deg)) + SUM_W'(n_acc);
    end

    // Parse state update; the final character clears it for the next note.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg       <= 3'd0;
            r_acc       <= '0;
            r_oct       <= '0;
            r_rest_seen <= 1'b0;
        end else if (s1_move) begin
            if (r_last) begin
                r_deg       <= 3'd0;
                r_acc       <= '0;
                r_oct       <= '0;
                r_rest_seen <= 1'b0;
            end else begin
                r_deg       <= n_deg;
                r_acc       <= n_acc;
                r_oct       <= n_oct;
                r_rest_seen <= n_rest_seen;
            end
        end
    end

    // Parse stage register holds one finished note.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (s1_move && r_last) begin
            r_s_valid <= 1'b1;
        end else if (s2_move) begin
            r_s_valid <= 1'b0;
        end
        if (s1_move && r_last) begin
            r_s_rest <= n_rest_seen || (n_deg == 3'd0);
            r_s_sum  <= p_sum;
            r_s_oct  <= n_oct;
        end
    end

    // Divide the biased sum by 12: reciprocal multiply, then one correction step.
    always_comb begin
        prod     = PROD_W'(r_s_sum) * PROD_W'(DIV_M);
        q0       = prod[PROD_W-1:DIV_K];
        r0       = r_s_sum - (SUM_W'(q0) << 3) - (SUM_W'(q0) << 2);
        over     = (r0[4:0] >= 5'd12);
        pc       = over ? 4'(r0[4:0] - 5'd12) : r0[3:0];
        q        = q0 + COUNT_WIDTH'(over);
        oct_full = OCT_W'(q) - Q_BIAS + OCT_W'(r_s_oct);
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s2_move) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
        if (s2_move) begin
            if (r_s_rest) begin
                r_o_base  <= 3'd0;
                r_o_sharp <= 1'b0;
                r_o_oct   <= 8'sd0;
                r_o_pc    <= 4'd0;
                r_o_mant  <= 16'd0;
            end else begin
                r_o_base  <= pc_degree(pc);
                r_o_sharp <= pc_sharp(pc);
                r_o_oct   <= oct_full[7:0];
                r_o_pc    <= pc;
                r_o_mant  <= ratio_mantissa(pc, MANTISSA_FRAC_BITS);
            end
        end
    end

    assign o_out.valid          = r_o_valid;
    assign o_out.base_digit     = r_o_base;
    assign o_out.sharp_flag     = r_o_sharp;
    assign o_out.octave         = r_o_oct;
    assign o_out.pitch_class    = r_o_pc;
    assign o_out.ratio_mantissa = r_o_mant;

    // The pitch class from the divider never reaches 12.
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_pc < 4'd12))
        else $error("pitch class out of range");

    // A rest result carries no ratio.
    a_rest_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_base == 3'd0) |-> (r_o_mant == 16'd0 && r_o_pc == 4'd0))
        else $error("rest result with nonzero fields");

    // The final character of a note leaves the parse state cleared.
    a_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && r_last) |=> (r_deg == 3'd0 && r_acc == '0 && r_oct == '0
                                 && !r_rest_seen))
        else $error("parse state not cleared after final character");

    // A new result is only loaded from a finished note in the parse stage.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_s_valid))
        else $error("result appeared without a finished note");

endmodule
